@@ rtl/core/bjsv_pkg.sv @@
// Shared types and constants for the binary JSON stream validator.
`default_nettype none
package bjsv_pkg;

    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_TAG_OBJECT  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAG_ARRAY   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAG_STRING  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAG_DOUBLE  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAG_INTEGER = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAG_TRUE    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAG_FALSE   = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAG_NULL    = 3'd7;

    // Kind of value whose varint is being read
    localparam logic [1:0] KIND_OBJECT  = 2'd0;
    localparam logic [1:0] KIND_ARRAY   = 2'd1;
    localparam logic [1:0] KIND_STRING  = 2'd2;
    localparam logic [1:0] KIND_INTEGER = 2'd3;

    // Parse phase
    localparam logic [1:0] PH_TAG     = 2'd0;
    localparam logic [1:0] PH_VARINT  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    typedef struct packed {
        logic [7:0] tag_object;
        logic [7:0] tag_array;
        logic [7:0] tag_string;
        logic [7:0] tag_double;
        logic [7:0] tag_integer;
        logic [7:0] tag_true;
        logic [7:0] tag_false;
        logic [7:0] tag_null;
    } tags_t;

    // Controller to datapath
    typedef struct packed {
        logic consume;   // run one byte through the parser
        logic pop_step;  // test top of stack and pop if it closes here
        logic clear;     // end of message: return to reset state
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_pop;  // a close check or stack refill is pending
        logic ok;        // no error and one complete value
    } dp_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/bjsv_datapath.sv @@
// Parser datapath: position, varint, nesting stack and error tracking.
`default_nettype none
module bjsv_datapath #(
    parameter int STACK_DEPTH = 16,
    parameter int POS_BITS    = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bjsv_pkg::tags_t    tags,
    input  wire logic [7:0]         data_byte,
    input  wire bjsv_pkg::dp_cmd_t  cmd,
    output bjsv_pkg::dp_stat_t      stat
);
    localparam int LVL_BITS = $clog2(STACK_DEPTH + 1);
    localparam int IDX_BITS = $clog2(STACK_DEPTH);
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
    localparam logic [LVL_BITS-1:0] LVL_FULL = LVL_BITS'(STACK_DEPTH);

    // stack memory, undefined until written
    logic [POS_BITS-1:0] end_mem [STACK_DEPTH];
    logic                obj_mem [STACK_DEPTH];
    logic                key_mem [STACK_DEPTH];

    // cached top of stack
    logic [POS_BITS-1:0] top_end_reg, top_end_next;
    logic                top_obj_reg, top_obj_next;
    logic                top_key_reg, top_key_next;

    logic [LVL_BITS-1:0] level_reg, level_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [1:0]          phase_reg, phase_next;
    logic [1:0]          kind_reg, kind_next;
    logic [63:0]         acc_reg, acc_next;
    logic [3:0]          vcnt_reg, vcnt_next;
    logic [POS_BITS-1:0] pend_reg, pend_next;
    logic                done_reg, done_next;
    logic                err_reg, err_next;
    logic                popchk_reg, popchk_next;
    logic                refill_reg, refill_next;

    // stack memory ports
    logic                wr_en;
    logic [IDX_BITS-1:0] wr_idx;
    logic [POS_BITS-1:0] wr_end;
    logic                wr_obj, wr_key;
    logic [IDX_BITS-1:0] rd_idx;
    logic [POS_BITS-1:0] rd_end_reg;
    logic                rd_obj_reg, rd_key_reg;

    logic [POS_BITS-1:0] q, room;
    logic [63:0]         acc_new;
    logic [6:0]          shamt;
    logic                len_fits;
    logic [POS_BITS:0]   end_sum;

    always_comb
    begin
        q = pos_reg + 1'b1;
        room = (level_reg != '0) ? (top_end_reg - q) : (POS_MAX - q);
        shamt = 7'(vcnt_reg) * 7'd7;
        acc_new = acc_reg;
        if (shamt < 7'd64)
        begin
            acc_new = acc_reg | (64'(data_byte[6:0]) << shamt[5:0]);
        end
        len_fits = (acc_new <= 64'(room));
        end_sum = {1'b0, q} + (POS_BITS+1)'(acc_new[POS_BITS-1:0]);
    end

    always_comb
    begin
        top_end_next = top_end_reg;
        top_obj_next = top_obj_reg;
        top_key_next = top_key_reg;
        level_next   = level_reg;
        pos_next     = pos_reg;
        phase_next   = phase_reg;
        kind_next    = kind_reg;
        acc_next     = acc_reg;
        vcnt_next    = vcnt_reg;
        pend_next    = pend_reg;
        done_next    = done_reg;
        err_next     = err_reg;
        popchk_next  = 1'b0;
        refill_next  = 1'b0;
        wr_en  = 1'b0;
        wr_idx = level_reg[IDX_BITS-1:0];
        wr_end = q + acc_new[POS_BITS-1:0];
        wr_obj = (kind_reg == bjsv_pkg::KIND_OBJECT);
        wr_key = 1'b1;
        rd_idx = IDX_BITS'(level_reg - 2'd2);

        if (refill_reg)
        begin
            top_end_next = rd_end_reg;
            top_obj_next = rd_obj_reg;
            top_key_next = rd_key_reg;
        end

        if (cmd.clear)
        begin
            level_next = '0;
            pos_next   = '0;
            phase_next = bjsv_pkg::PH_TAG;
            kind_next  = bjsv_pkg::KIND_OBJECT;
            acc_next   = '0;
            vcnt_next  = '0;
            pend_next  = '0;
            done_next  = 1'b0;
            err_next   = 1'b0;
        end
        else if (cmd.consume && !err_reg)
        begin
            if (done_reg || pos_reg == POS_MAX)
            begin
                err_next = 1'b0 | 1'b1;
            end
            else
            begin
                priority if (phase_reg == bjsv_pkg::PH_TAG)
                begin
                    logic key_due;
                    logic bad;
                    key_due = (level_reg != '0) && top_obj_reg && top_key_reg;
                    bad = 1'b0;
                    if (level_reg != '0 && top_obj_reg)
                    begin
                        top_key_next = !top_key_reg;
                        wr_en  = 1'b1;
                        wr_idx = IDX_BITS'(level_reg - 1'b1);
                        wr_end = top_end_reg;
                        wr_obj = top_obj_reg;
                        wr_key = !top_key_reg;
                    end
                    acc_next  = '0;
                    vcnt_next = '0;
                    priority if (key_due)
                    begin
                        if (data_byte != tags.tag_string)
                        begin
                            bad = 1'b1;
                        end
                        else
                        begin
                            phase_next = bjsv_pkg::PH_VARINT;
                            kind_next  = bjsv_pkg::KIND_STRING;
                        end
                    end
                    else if (data_byte == tags.tag_object)
                    begin
                        phase_next = bjsv_pkg::PH_VARINT;
                        kind_next  = bjsv_pkg::KIND_OBJECT;
                    end
                    else if (data_byte == tags.tag_array)
                    begin
                        phase_next = bjsv_pkg::PH_VARINT;
                        kind_next  = bjsv_pkg::KIND_ARRAY;
                    end
                    else if (data_byte == tags.tag_string)
                    begin
                        phase_next = bjsv_pkg::PH_VARINT;
                        kind_next  = bjsv_pkg::KIND_STRING;
                    end
                    else if (data_byte == tags.tag_double)
                    begin
                        if (room < POS_BITS'(8))
                        begin
                            bad = 1'b1;
                        end
                        else
                        begin
                            pend_next  = q + POS_BITS'(8);
                            phase_next = bjsv_pkg::PH_PAYLOAD;
                        end
                    end
                    else if (data_byte == tags.tag_integer)
                    begin
                        phase_next = bjsv_pkg::PH_VARINT;
                        kind_next  = bjsv_pkg::KIND_INTEGER;
                    end
                    else if (data_byte == tags.tag_true || data_byte == tags.tag_false
                             || data_byte == tags.tag_null)
                    begin
                        phase_next = bjsv_pkg::PH_TAG;
                    end
                    else
                    begin
                        bad = 1'b1;
                    end
                    if (bad)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        pos_next    = q;
                        popchk_next = 1'b1;
                    end
                end
                else if (phase_reg == bjsv_pkg::PH_VARINT)
                begin
                    acc_next  = acc_new;
                    vcnt_next = vcnt_reg + 1'b1;
                    if (data_byte[7])
                    begin
                        if (vcnt_reg >= 4'd9)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            pos_next    = q;
                            popchk_next = 1'b1;
                        end
                    end
                    else
                    begin
                        phase_next = bjsv_pkg::PH_TAG;
                        unique case (kind_reg)
                            bjsv_pkg::KIND_STRING:
                            begin
                                if (!len_fits)
                                begin
                                    err_next = 1'b1;
                                end
                                else
                                begin
                                    if (acc_new != '0)
                                    begin
                                        pend_next  = end_sum[POS_BITS-1:0];
                                        phase_next = bjsv_pkg::PH_PAYLOAD;
                                    end
                                    pos_next    = q;
                                    popchk_next = 1'b1;
                                end
                            end
                            bjsv_pkg::KIND_OBJECT, bjsv_pkg::KIND_ARRAY:
                            begin
                                if (!len_fits || level_reg >= LVL_FULL)
                                begin
                                    err_next = 1'b1;
                                end
                                else
                                begin
                                    wr_en  = 1'b1;
                                    wr_idx = level_reg[IDX_BITS-1:0];
                                    wr_end = end_sum[POS_BITS-1:0];
                                    wr_obj = (kind_reg == bjsv_pkg::KIND_OBJECT);
                                    wr_key = 1'b1;
                                    top_end_next = end_sum[POS_BITS-1:0];
                                    top_obj_next = wr_obj;
                                    top_key_next = 1'b1;
                                    level_next   = level_reg + 1'b1;
                                    pos_next     = q;
                                    popchk_next  = 1'b1;
                                end
                            end
                            default:
                            begin
                                pos_next    = q;
                                popchk_next = 1'b1;
                            end
                        endcase
                    end
                end
                else
                begin
                    if (q == pend_reg)
                    begin
                        phase_next = bjsv_pkg::PH_TAG;
                    end
                    pos_next    = q;
                    popchk_next = 1'b1;
                end
            end
        end
        else if (cmd.pop_step && !err_reg && !refill_reg)
        begin
            // one close check per cycle; the refill cycle loads the new top
            if (phase_reg != bjsv_pkg::PH_TAG)
            begin
                if (level_reg != '0 && top_end_reg == pos_reg)
                begin
                    err_next = 1'b1;
                end
            end
            else if (level_reg != '0 && top_end_reg == pos_reg)
            begin
                if (top_obj_reg && !top_key_reg)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    level_next = level_reg - 1'b1;
                    if (level_reg == LVL_BITS'(1))
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        refill_next = 1'b1;
                        popchk_next = 1'b1;
                    end
                end
            end
            else if (level_reg == '0)
            begin
                done_next = 1'b1;
            end
        end
        else if (cmd.pop_step && refill_reg)
        begin
            popchk_next = popchk_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            end_mem[wr_idx] <= wr_end;
            obj_mem[wr_idx] <= wr_obj;
            key_mem[wr_idx] <= wr_key;
        end
        rd_end_reg <= end_mem[rd_idx];
        rd_obj_reg <= obj_mem[rd_idx];
        rd_key_reg <= key_mem[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg  <= '0;
            pos_reg    <= '0;
            phase_reg  <= bjsv_pkg::PH_TAG;
            kind_reg   <= bjsv_pkg::KIND_OBJECT;
            acc_reg    <= '0;
            vcnt_reg   <= '0;
            pend_reg   <= '0;
            done_reg   <= 1'b0;
            err_reg    <= 1'b0;
            popchk_reg <= 1'b0;
            refill_reg <= 1'b0;
        end
        else
        begin
            level_reg  <= level_next;
            pos_reg    <= pos_next;
            phase_reg  <= phase_next;
            kind_reg   <= kind_next;
            acc_reg    <= acc_next;
            vcnt_reg   <= vcnt_next;
            pend_reg   <= pend_next;
            done_reg   <= done_next;
            err_reg    <= err_next;
            popchk_reg <= popchk_next;
            refill_reg <= refill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_end_reg <= top_end_next;
        top_obj_reg <= top_obj_next;
        top_key_reg <= top_key_next;
    end

    always_comb
    begin
        stat.need_pop = (popchk_reg || refill_reg) && !err_reg;
        stat.ok       = !err_reg && done_reg;
    end

endmodule
`default_nettype wire

@@ rtl/core/bjsv_ctrl.sv @@
// Controller: takes a byte, runs the close checks, then after the last byte delivers the flag.
`default_nettype none
module bjsv_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               in_last,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    out_flag,
    output bjsv_pkg::dp_cmd_t       cmd,
    input  wire bjsv_pkg::dp_stat_t stat
);
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CLOSE = 2'd1;
    localparam logic [1:0] ST_OUT   = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       last_reg, last_next;
    logic       ovalid_reg, ovalid_next;
    logic       oflag_reg, oflag_next;
    logic       accept;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        last_next   = last_reg;
        ovalid_next = ovalid_reg && out_stall;
        oflag_next  = oflag_reg;
        cmd.consume  = accept;
        cmd.pop_step = 1'b0;
        cmd.clear    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    last_next  = in_last;
                    state_next = ST_CLOSE;
                end
            end
            ST_CLOSE:
            begin
                cmd.pop_step = 1'b1;
                if (!stat.need_pop)
                begin
                    cmd.pop_step = 1'b0;
                    state_next = last_reg ? ST_OUT : ST_IDLE;
                end
            end
            ST_OUT:
            begin
                // wait for the output register to drain
                if (!ovalid_reg || !out_stall)
                begin
                    ovalid_next = 1'b1;
                    oflag_next  = stat.ok;
                    cmd.clear   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            last_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            last_reg   <= last_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oflag_reg <= oflag_next;
    end

    assign out_valid = ovalid_reg;
    assign out_flag  = oflag_reg;

endmodule
`default_nettype wire

@@ rtl/core/bjsv_cfg.sv @@
// Tag configuration registers.
`default_nettype none
module bjsv_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [bjsv_pkg::CFG_IDX_BITS-1:0] cfg_idx,
    input  wire logic [7:0]                        cfg_data,
    output bjsv_pkg::tags_t                        tags
);
    bjsv_pkg::tags_t tags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tags_reg.tag_object  <= 8'd1;
            tags_reg.tag_array   <= 8'd2;
            tags_reg.tag_string  <= 8'd3;
            tags_reg.tag_double  <= 8'd4;
            tags_reg.tag_integer <= 8'd5;
            tags_reg.tag_true    <= 8'd6;
            tags_reg.tag_false   <= 8'd7;
            tags_reg.tag_null    <= 8'd8;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                bjsv_pkg::CFG_TAG_OBJECT:  tags_reg.tag_object  <= cfg_data;
                bjsv_pkg::CFG_TAG_ARRAY:   tags_reg.tag_array   <= cfg_data;
                bjsv_pkg::CFG_TAG_STRING:  tags_reg.tag_string  <= cfg_data;
                bjsv_pkg::CFG_TAG_DOUBLE:  tags_reg.tag_double  <= cfg_data;
                bjsv_pkg::CFG_TAG_INTEGER: tags_reg.tag_integer <= cfg_data;
                bjsv_pkg::CFG_TAG_TRUE:    tags_reg.tag_true    <= cfg_data;
                bjsv_pkg::CFG_TAG_FALSE:   tags_reg.tag_false   <= cfg_data;
                bjsv_pkg::CFG_TAG_NULL:    tags_reg.tag_null    <= cfg_data;
                default:                   tags_reg.tag_null    <= tags_reg.tag_null;
            endcase
        end
    end

    assign tags = tags_reg;

endmodule
`default_nettype wire

@@ rtl/core/binary_json_stream_validator_unit.sv @@
// Top level of the binary JSON stream validator.
//
//  channel | signals                          | dir | payload
//  in      | in_valid / in_stall              | in  | data_byte, last_byte
//  out     | out_valid / out_stall            | out | message_valid (last byte only)
//  cfg     | cfg_we, cfg_index, cfg_data      | in  | tag registers 0..7
//
// A byte goes through the transfer, one close check and the return to idle;
// a byte that raises the error returns to idle with no close check. Each
// container it closes while another stays open adds a stack memory read to
// reload the top, then a recheck. The last byte loads the output register.
// Reset clears the parse state; the cached top and the stack memory need no
// clearing. A stalled output holds the next last byte until the flag is taken.
`default_nettype none
module binary_json_stream_validator_unit #(
    parameter int STACK_DEPTH = 16,
    parameter int POS_BITS    = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            message_valid,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_data
);
    bjsv_pkg::tags_t    tags;
    bjsv_pkg::dp_cmd_t  cmd;
    bjsv_pkg::dp_stat_t stat;

    bjsv_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_index),
        .cfg_data(cfg_data), .tags(tags)
    );

    bjsv_datapath #(.STACK_DEPTH(STACK_DEPTH), .POS_BITS(POS_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .tags(tags), .data_byte(data_byte),
        .cmd(cmd), .stat(stat)
    );

    bjsv_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_last(last_byte), .out_valid(out_valid), .out_stall(out_stall),
        .out_flag(message_valid), .cmd(cmd), .stat(stat)
    );

endmodule
`default_nettype wire

@@ rtl/core/bjsv_checker.sv @@
// Port-level checks for the validator, bound to the top level.
`default_nettype none
module bjsv_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic last_byte,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire logic message_valid
);
    // a new result is loaded only while the input side is held off
    a_out_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result loaded while input was open");

    // a transfer that is not the last byte never directly raises a result
    a_no_out_mid_msg: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !last_byte) |=> !$rose(out_valid))
        else $error("result in the middle of a message");

    // after any transfer the block is busy for the next cycle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken back to back");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(message_valid)))
        else $error("stalled result changed");

endmodule

bind binary_json_stream_validator_unit bjsv_checker u_bjsv_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .last_byte(last_byte), .out_valid(out_valid), .out_stall(out_stall),
    .message_valid(message_valid)
);
`default_nettype wire
